FILE: rtl/core/assert_macros.svh
// Assertion macros for the core RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define SKTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SKTH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/skth_pkg.sv
// Shared constants and helpers for the k-th largest tracker.
// No dependencies; used by skth_heap_ram and the top level.
package skth_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RankW = 7;

  // Result value while the heap is not yet full.
  localparam logic [DataW-1:0] KthEmpty = {DataW{1'b1}};

  // Signed greater-than on two's complement words.
  function automatic logic sgt(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    return $signed(a) > $signed(b);
  endfunction

endpackage

FILE: rtl/core/skth_heap_ram.sv
// Heap entry store: one write port, two registered read ports.
// Depends on skth_pkg for the data width.
module skth_heap_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [skth_pkg::DataW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_a_i,
  input  logic [AddrW-1:0]          raddr_b_i,
  output logic [skth_pkg::DataW-1:0] rdata_a_o,
  output logic [skth_pkg::DataW-1:0] rdata_b_o
);

  logic [skth_pkg::DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

FILE: rtl/core/streaming_kth_largest_tracker.sv
// Streaming k-th largest tracker: min-heap of the k largest samples.
// Depends on skth_pkg, skth_heap_ram and assert_macros.svh.
//
// Usage:
//   Input stream s_axis carries one signed 32-bit sample per transfer.
//   Output stream m_axis returns one result per sample: tdata is the
//   current k-th largest value (all ones while the heap is not full) and
//   tuser is the full flag.
//   cfg_we_i/cfg_wdata_i write rank_k (7 bits). A write also empties the
//   heap; write only while the block is idle. Rank 0 acts as 1, a rank
//   above CAPACITY acts as CAPACITY.
//   A dropped sample goes straight to the done state; a kept one sifts up
//   or down first. Each heap level passes through a read state and a
//   compare/write state on the heap RAM; that loop sets the rate, one
//   sample at a time: the next sample is taken the cycle after the result
//   loads.
//   The root is mirrored in a register, so the drop decision needs no read.
//   Reset: rank_k returns to 1 and the heap is empty; the RAM itself is not
//   cleared, since entries at or above the fill count are never used.
//   Stall: a finished result waits in the output register; the next sample
//   is accepted meanwhile, and its result holds in the last state until the
//   register frees up.
`include "assert_macros.svh"

module streaming_kth_largest_tracker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata: [31:0] sample_value
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // m_axis_tdata: [31:0] kth_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  // m_axis_tuser: [0] heap_full
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);

  localparam int unsigned DW = skth_pkg::DataW;
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // heap index
  localparam int unsigned HW = $clog2(CAPACITY + 1);                    // fill count
  localparam int unsigned CW = (HW > skth_pkg::RankW) ? HW : skth_pkg::RankW;
  localparam int unsigned LW = IW + 2;                                  // child index math

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StUpRd  = 3'd1;
  localparam logic [2:0] StUpCmp = 3'd2;
  localparam logic [2:0] StDnRd  = 3'd3;
  localparam logic [2:0] StDnCmp = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [IW-1:0]               pos_q, pos_d;
  logic [DW-1:0]               val_q, val_d;
  logic [HW-1:0]               held_q, held_d;
  logic [skth_pkg::RankW-1:0]  rank_q;
  logic [DW-1:0]               root_q;
  logic                        out_valid_q;
  logic [DW-1:0]               out_data_q;
  logic                        out_full_q;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [DW-1:0]               ram_wdata;
  logic                        ram_re;
  logic [IW-1:0]               ram_raddr_a, ram_raddr_b;
  logic [DW-1:0]               ram_rdata_a, ram_rdata_b;

  logic [CW-1:0]               eff_k;
  logic                        is_full;
  logic                        in_xfer;
  logic                        out_free;
  logic [LW-1:0]               lc_idx, rc_idx, held_ext;
  logic                        lc_ok, rc_ok;
  logic [IW-1:0]               par_idx;
  logic                        take_l, take_r;
  logic [DW-1:0]               best_lv;

  // Clamp the rank into 1..CAPACITY.
  always_comb begin
    eff_k = CW'(rank_q);
    if (eff_k == '0) begin
      eff_k = CW'(1);
    end else if (eff_k > CW'(CAPACITY)) begin
      eff_k = CW'(CAPACITY);
    end
  end

  assign is_full  = CW'(held_q) >= eff_k;
  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Child and parent positions of the hole.
  assign lc_idx   = LW'({pos_q, 1'b1});
  assign rc_idx   = lc_idx + LW'(1);
  assign held_ext = LW'(held_q);
  assign lc_ok    = lc_idx < held_ext;
  assign rc_ok    = rc_idx < held_ext;
  assign par_idx  = IW'((pos_q - IW'(1)) >> 1);

  // Sift-down choice: parent wins ties, then the left child.
  assign take_l  = skth_pkg::sgt(val_q, ram_rdata_a);
  assign best_lv = take_l ? ram_rdata_a : val_q;
  assign take_r  = rc_ok && skth_pkg::sgt(best_lv, ram_rdata_b);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    val_d       = val_q;
    held_d      = held_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = val_q;
    ram_re      = 1'b0;
    ram_raddr_a = par_idx;
    ram_raddr_b = par_idx;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          val_d = s_axis_tdata;
          if (!is_full) begin
            // Append at the end and sift up.
            pos_d   = IW'(held_q);
            held_d  = held_q + HW'(1);
            state_d = StUpRd;
          end else if (skth_pkg::sgt(s_axis_tdata, root_q)) begin
            // Replace the root and sift down.
            pos_d   = '0;
            state_d = StDnRd;
          end else begin
            state_d = StDone;
          end
        end
      end
      StUpRd: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = StDone;
        end else begin
          ram_re  = 1'b1;
          state_d = StUpCmp;
        end
      end
      StUpCmp: begin
        ram_we = 1'b1;
        if (skth_pkg::sgt(ram_rdata_a, val_q)) begin
          // Move the parent down into the hole.
          ram_wdata = ram_rdata_a;
          pos_d     = par_idx;
          state_d   = StUpRd;
        end else begin
          state_d = StDone;
        end
      end
      StDnRd: begin
        ram_raddr_a = IW'(lc_idx);
        ram_raddr_b = IW'(rc_idx);
        if (!lc_ok) begin
          ram_we  = 1'b1;
          state_d = StDone;
        end else begin
          ram_re  = 1'b1;
          state_d = StDnCmp;
        end
      end
      StDnCmp: begin
        ram_we = 1'b1;
        if (take_r) begin
          ram_wdata = ram_rdata_b;
          pos_d     = IW'(rc_idx);
          state_d   = StDnRd;
        end else if (take_l) begin
          ram_wdata = ram_rdata_a;
          pos_d     = IW'(lc_idx);
          state_d   = StDnRd;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A rank write restarts tracking.
    if (cfg_we_i) begin
      held_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      held_q  <= '0;
      rank_q  <= skth_pkg::RankW'(1);
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      if (cfg_we_i) begin
        rank_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    // Mirror every write to the root entry.
    if (ram_we && (ram_waddr == '0)) begin
      root_q <= ram_wdata;
    end
  end

  // Output register: load the finished result, drop it once transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == StDone) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StDone) && out_free) begin
      out_full_q <= is_full;
      out_data_q <= is_full ? root_q : skth_pkg::KthEmpty;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_full_q;

  skth_heap_ram #(
    .Depth (CAPACITY),
    .AddrW (IW)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  `SKTH_ASSERT(a_held_le_rank, CW'(held_q) <= eff_k, "fill count exceeds rank")
  `SKTH_ASSERT(a_write_in_heap, ram_we |-> (HW'(ram_waddr) < held_q), "write beyond heap fill")
  `SKTH_ASSERT(a_root_mirror, (ram_we && (ram_waddr == '0)) |=> (root_q == $past(ram_wdata)), "root mirror out of step")

endmodule

FILE: bench/tb.sv
// Self-checking bench for streaming_kth_largest_tracker: drives sample streams,
// predicts each k-th largest result in a local min-heap and scores the output.
// Depends on skth_pkg and the tracker RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned HEAP_DEPTH = 64;
  // Longest run of cycles with no transfer on either stream before giving up.
  localparam int unsigned STALL_LIMIT = 2000;
  // Quiet cycles after the last result, to catch stray transfers.
  localparam int unsigned TAIL_CYCLES = 32;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [skth_pkg::DataW-1:0] kth_value;
    logic                       heap_full;
  } kth_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [31:0]                s_axis_tdata;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [31:0]                m_axis_tdata;
  logic                       m_axis_tuser;
  logic                       cfg_we_i;
  logic [skth_pkg::RankW-1:0] cfg_wdata_i;

  // Local copy of the tracker state, updated at every accepted sample.
  logic [31:0]                heap_mirror [HEAP_DEPTH];
  int unsigned                fill_count;
  logic [skth_pkg::RankW-1:0] rank_reg;

  // Results still owed by the block, oldest first.
  kth_result_t kth_expected[$];

  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  // Running value for monotonic stretches of the random stream.
  logic [31:0] ramp_value;
  logic [31:0] ramp_step;

  kth_result_t got_result;
  kth_result_t want_result;

  streaming_kth_largest_tracker #(
    .CAPACITY(HEAP_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic swap_entries(input int unsigned a, input int unsigned b);
    logic [31:0] tmp;
    tmp            = heap_mirror[a];
    heap_mirror[a] = heap_mirror[b];
    heap_mirror[b] = tmp;
  endtask

  // Apply one sample to the local heap and queue the result it must produce.
  task automatic track_sample(input logic [31:0] value);
    int unsigned k;
    int unsigned pos;
    int unsigned par;
    int unsigned lc;
    int unsigned rc;
    int unsigned best;
    bit          done;
    kth_result_t res;
    // Clamp the rank into 1..HEAP_DEPTH, as the block does.
    k = 32'(rank_reg);
    if (k < 1) k = 1;
    if (k > HEAP_DEPTH) k = HEAP_DEPTH;
    if (fill_count < k) begin
      // Still filling: append and sift up while the parent is strictly larger.
      heap_mirror[fill_count] = value;
      pos  = fill_count;
      done = 1'b0;
      while (pos > 0 && !done) begin
        par = (pos - 1) / 2;
        if ($signed(heap_mirror[par]) > $signed(heap_mirror[pos])) begin
          swap_entries(par, pos);
          pos = par;
        end else begin
          done = 1'b1;
        end
      end
      fill_count++;
    end else if ($signed(value) > $signed(heap_mirror[0])) begin
      // Full: a larger sample replaces the root and sinks. Ties keep the
      // parent, then prefer the left child.
      heap_mirror[0] = value;
      pos  = 0;
      done = 1'b0;
      while (!done) begin
        best = pos;
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        if (lc < fill_count && $signed(heap_mirror[best]) > $signed(heap_mirror[lc])) best = lc;
        if (rc < fill_count && $signed(heap_mirror[best]) > $signed(heap_mirror[rc])) best = rc;
        if (best == pos) begin
          done = 1'b1;
        end else begin
          swap_entries(best, pos);
          pos = best;
        end
      end
    end
    // Otherwise the sample is dropped and the heap is untouched.
    if (fill_count >= k) begin
      res.kth_value = heap_mirror[0];
      res.heap_full = 1'b1;
    end else begin
      res.kth_value = skth_pkg::KthEmpty;
      res.heap_full = 1'b0;
    end
    kth_expected.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and scoring
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input kth_result_t want,
                                 input kth_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected kth_value=%h heap_full=%b, got kth_value=%h heap_full=%b",
               $realtime, what, want.kth_value, want.heap_full, got.kth_value, got.heap_full);
    end
  endtask

  // Drop tready at random on the falling edge, at the rate of the current phase.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Score every output transfer against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_result.kth_value = m_axis_tdata;
      got_result.heap_full = m_axis_tuser;
      if (kth_expected.size() == 0) begin
        report_mismatch("result with nothing owed", '0, got_result);
      end else begin
        want_result = kth_expected.pop_front();
        if (got_result.kth_value !== want_result.kth_value ||
            got_result.heap_full !== want_result.heap_full) begin
          report_mismatch("result mismatch", want_result, got_result);
        end
      end
    end
  end

  // Give up when neither stream moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------

  // Offer one sample; call and return on the falling edge. tvalid stays high
  // on return so back-to-back samples need no extra low cycle.
  task automatic send_sample(input logic [31:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    do @(posedge clk_i); while (!s_axis_tready);
    track_sample(value);
    @(negedge clk_i);
  endtask

  // Hold off the sample stream until every owed result has come back.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (kth_expected.size() != 0) @(negedge clk_i);
  endtask

  // Write rank_k with the block idle; the write also empties the heap.
  task automatic write_rank(input logic [skth_pkg::RankW-1:0] rank);
    drain_results();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = rank;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    rank_reg   = rank;
    fill_count = 0;
  endtask

  // Mix of full-range words, narrow values that tie often, the signed
  // extremes and monotonic ramps that force long sifts or steady drops.
  function automatic logic [31:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return $urandom;
    if (r < 70) return 32'($urandom_range(16)) - 32'd8;
    if (r < 80) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    ramp_value = ramp_value + ramp_step;
    return ramp_value;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Rank comes out of reset as 1: the result tracks the running maximum.
  task automatic test_reset_rank();
    send_sample(32'd5);
    send_sample(-32'sd3);
    send_sample(32'd9);
  endtask

  // Rank 0 must behave as rank 1.
  task automatic test_rank_zero();
    write_rank(7'd0);
    send_sample(32'd7);
    send_sample(32'd2);
    send_sample(32'd11);
  endtask

  // Signed extremes, including drops of the most negative value.
  task automatic test_signed_extremes();
    write_rank(7'd3);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0001);
  endtask

  // Equal values: an equal sample is dropped, tied children sift left first.
  task automatic test_equal_values();
    write_rank(7'd4);
    send_sample(32'd5);
    send_sample(32'd5);
    send_sample(32'd5);
    send_sample(32'd5);
    send_sample(32'd5);
    send_sample(32'd6);
    send_sample(32'd7);
  endtask

  // A rank write after a partial fill restarts tracking with the new rank.
  task automatic test_rank_restart();
    write_rank(7'd5);
    send_sample(32'd100);
    send_sample(32'd200);
    write_rank(7'd2);
    send_sample(32'd1);
    send_sample(32'd300);
    send_sample(32'd2);
  endtask

  // Random streams over six rank settings per idle phase, with the clamp
  // cases (0 and above the capacity) and a full heap among them.
  task automatic test_random_stream(input int unsigned phase, input int unsigned tx_pct,
                                    input int unsigned rx_pct);
    logic [skth_pkg::RankW-1:0] rank_plan [18] = '{
      7'd1, 7'd64, 7'd0,  7'd7,  7'd127, 7'd3,
      7'd2, 7'd65, 7'd5,  7'd12, 7'd100, 7'd31,
      7'd4, 7'd64, 7'd1,  7'd9,  7'd40,  7'd0
    };
    logic [skth_pkg::RankW-1:0] rank;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int s = 0; s < 6; s++) begin
      rank = rank_plan[phase * 6 + s];
      if (s == 5) rank = skth_pkg::RankW'($urandom_range(127));
      write_rank(rank);
      ramp_value = $urandom;
      ramp_step  = 32'($urandom_range(1, 1000));
      if ($urandom_range(1)) ramp_step = -ramp_step;
      for (int n = 0; n < 75; n++) begin
        // Let the block run dry once per setting.
        if (n == 37) drain_results();
        send_sample(pick_sample());
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    fill_count     = 0;
    rank_reg       = 7'd1;
    ramp_value     = '0;
    ramp_step      = 32'd1;
    tx_idle_pct    = 10;
    rx_idle_pct    = 54;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_rank();
    test_rank_zero();
    test_signed_extremes();
    test_equal_values();
    test_rank_restart();
    test_random_stream(0, 10, 54);
    test_random_stream(1, 54, 10);
    test_random_stream(2, 0, 0);

    // Collect what is owed, then watch for stray results.
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && kth_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/skth_pkg.sv
rtl/core/skth_heap_ram.sv
rtl/core/streaming_kth_largest_tracker.sv
bench/tb.sv
